>>> hw/rtl/mtg_pkg.sv
// Shared definitions for the multi-context MT19937 generator.
// Holds the generator constants, item mode codes and the tempering function.
// No dependencies; compiled before every other file of the block.
package mtg_pkg;

    localparam int CONTEXTS_DEF = 4;
    localparam int MAX_KEY_DEF  = 8;

    localparam int WORDS        = 624;
    localparam int SHIFT_OFS    = 397;
    localparam int NEVER_SEEDED = 625;

    localparam int CTX_W  = 2;
    localparam int POS_W  = 10;
    localparam int WORD_W = 32;

    localparam logic [WORD_W-1:0] TWIST_XOR   = 32'h9908b0df;
    localparam logic [WORD_W-1:0] TEMPER_B    = 32'h9d2c5680;
    localparam logic [WORD_W-1:0] TEMPER_C    = 32'hefc60000;
    localparam logic [WORD_W-1:0] INIT_MULT   = 32'd1812433253;
    localparam logic [WORD_W-1:0] KEY_MULT_1  = 32'd1664525;
    localparam logic [WORD_W-1:0] KEY_MULT_2  = 32'd1566083941;
    localparam logic [WORD_W-1:0] KEY_SEED    = 32'd19650218;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
    localparam logic [WORD_W-1:0] HIGH_BIT    = 32'h80000000;

    typedef enum logic [1:0] {
        MODE_SEED = 2'd0,
        MODE_KEY  = 2'd1,
        MODE_GEN  = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] v;
        v = w;
        v = v ^ (v >> 11);
        v = v ^ ((v << 7) & TEMPER_B);
        v = v ^ ((v << 15) & TEMPER_C);
        v = v ^ (v >> 18);
        return v;
    endfunction

endpackage

>>> hw/rtl/mt19937_multi_context_generator_unit.sv
// Top level of the multi-context MT19937 generator.
// Depends on mtg_pkg and instantiates mtg_ram for state words and key buffer.
//
// This block runs CONTEXTS independent 32-bit Mersenne Twister generators whose
// 624-word states share one RAM (mirrored in two instances to give two read
// ports), driven by a single read-modify-write sequencer that handles one input
// transfer at a time. A generate transfer on a context with words left goes
// through accept, RAM read and temper before its result reaches the output
// register; the temper step waits while an earlier word is still held there.
// When the context is exhausted the twist is done in place first, with one RAM
// read and one write for each word. A generate on a context that was never
// seeded first seeds it with 5489. A seed transfer is limited by the one
// multiplier that each new word waits on. A key word without the last mark only
// goes into the key buffer; the last key word runs the whole array seeding. Key
// words of all contexts collect in one shared buffer of MAX_KEY words; further
// words are dropped. Items with mode 3 or a context at or beyond CONTEXTS are
// accepted and ignored. The result sits in an output register, so the next
// transfer is taken while a word still waits on the output side.
module mt19937_multi_context_generator_unit
    import mtg_pkg::*;
#(
    parameter int CONTEXTS = CONTEXTS_DEF,
    parameter int MAX_KEY  = MAX_KEY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic [CTX_W-1:0]  context_req,
    input  logic [WORD_W-1:0] value,
    input  logic              key_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] random_word,
    output logic [CTX_W-1:0]  source_context
);

    localparam int CIDX   = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int ADDR_W = $clog2(CONTEXTS * WORDS);
    localparam int KIDX   = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
    localparam int KCW    = $clog2(MAX_KEY + 1);

    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(WORDS - 1);
    localparam logic [POS_W-1:0] POS_WORDS = POS_W'(WORDS);
    localparam logic [POS_W-1:0] POS_NEVER = POS_W'(NEVER_SEEDED);
    localparam logic [POS_W-1:0] POS_FAR0  = POS_W'(SHIFT_OFS);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_SD_W0  = 14'b00000000000010,
        S_SD_MUL = 14'b00000000000100,
        S_SD_WR  = 14'b00000000001000,
        S_K_RD   = 14'b00000000010000,
        S_K_WR   = 14'b00000000100000,
        S_K_W0   = 14'b00000001000000,
        S_K_FIN  = 14'b00000010000000,
        S_T_PRE  = 14'b00000100000000,
        S_T_LD   = 14'b00001000000000,
        S_T_RD   = 14'b00010000000000,
        S_T_WR   = 14'b00100000000000,
        S_G_RD   = 14'b01000000000000,
        S_G_OUT  = 14'b10000000000000
    } seq_state_t;

    // What follows once single-value seeding of a context is finished.
    typedef enum logic [1:0] {
        FOLLOW_NONE  = 2'd0,
        FOLLOW_KEY   = 2'd1,
        FOLLOW_TWIST = 2'd2
    } follow_t;

    seq_state_t         state_reg, state_next;
    follow_t            follow_reg, follow_next;
    logic [CTX_W-1:0]   ctx_reg, ctx_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [POS_W-1:0]   i_reg, i_next;
    logic [POS_W-1:0]   k_reg, k_next;
    logic [POS_W-1:0]   far_reg, far_next;
    logic [KIDX-1:0]    j_reg, j_next;
    logic [KCW-1:0]     len_reg, len_next;
    logic               phase_reg, phase_next;
    logic [WORD_W-1:0]  prev_reg, prev_next;
    logic [WORD_W-1:0]  cur_reg, cur_next;
    logic [WORD_W-1:0]  mult_reg, mult_next;
    logic [KCW-1:0]     key_count_reg, key_count_next;
    logic [POS_W-1:0]   rp_reg [CONTEXTS];
    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_word_reg, out_word_next;
    logic [CTX_W-1:0]   out_ctx_reg, out_ctx_next;

    // Read position update port.
    logic               rp_we;
    logic [CIDX-1:0]    rp_idx;
    logic [POS_W-1:0]   rp_wdata;

    // State word RAM controls; write port and read enable are shared by both mirrored instances.
    logic               sw_we;
    logic [ADDR_W-1:0]  sw_waddr;
    logic [WORD_W-1:0]  sw_wdata;
    logic               sw_re;
    logic [ADDR_W-1:0]  sw_raddr_a, sw_raddr_b;
    logic [WORD_W-1:0]  sw_rdata_a, sw_rdata_b;

    // Key buffer RAM controls.
    logic               kb_we;
    logic [KIDX-1:0]    kb_waddr;
    logic               kb_re;
    logic [WORD_W-1:0]  kb_rdata;

    logic [CIDX-1:0]    cidx_in, cidx_reg;
    logic               ctx_ok;
    logic [WORD_W-1:0]  mult_const, mult_src;
    logic [WORD_W-1:0]  product;
    logic [POS_W-1:0]   k_limit;
    logic [KCW-1:0]     count_inc;
    logic [WORD_W-1:0]  key_mix, twist_v, new_word;
    logic [KCW-1:0]     j_plus;
    logic [POS_W-1:0]   rp_cur;

    assign cidx_in  = CIDX'(context_req);
    assign cidx_reg = CIDX'(ctx_reg);
    assign ctx_ok   = (32'(context_req) < CONTEXTS);
    assign rp_cur   = rp_reg[cidx_reg];

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign random_word    = out_word_reg;
    assign source_context = out_ctx_reg;

    // One shared multiplier; its product is registered before use.
    assign mult_src = prev_reg ^ (prev_reg >> 30);
    always_comb
    begin
        if (state_reg == S_SD_MUL)
        begin
            mult_const = INIT_MULT;
        end
        else if (phase_reg)
        begin
            mult_const = KEY_MULT_2;
        end
        else
        begin
            mult_const = KEY_MULT_1;
        end
    end
    assign product = mult_const * mult_src;

    // The first key loop runs 624 times, the second 623 times.
    assign k_limit   = phase_reg ? LAST_POS : POS_WORDS;
    assign count_inc = (32'(key_count_reg) < MAX_KEY) ? key_count_reg + 1'b1 : key_count_reg;
    assign key_mix   = sw_rdata_a ^ mult_reg;
    assign j_plus    = KCW'(j_reg) + 1'b1;
    assign twist_v   = (cur_reg & HIGH_BIT) | (sw_rdata_b & ~HIGH_BIT);

    always_comb
    begin
        if (phase_reg)
        begin
            new_word = key_mix - WORD_W'(i_reg);
        end
        else
        begin
            new_word = key_mix + kb_rdata + WORD_W'(j_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        follow_next    = follow_reg;
        ctx_next       = ctx_reg;
        base_next      = base_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        far_next       = far_reg;
        j_next         = j_reg;
        len_next       = len_reg;
        phase_next     = phase_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        mult_next      = mult_reg;
        key_count_next = key_count_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_word_next  = out_word_reg;
        out_ctx_next   = out_ctx_reg;
        rp_we          = 1'b0;
        rp_idx         = cidx_reg;
        rp_wdata       = rp_cur;
        sw_we          = 1'b0;
        sw_waddr       = base_reg;
        sw_wdata       = prev_reg;
        sw_re          = 1'b0;
        sw_raddr_a     = base_reg;
        sw_raddr_b     = base_reg;
        kb_we          = 1'b0;
        kb_waddr       = KIDX'(key_count_reg);
        kb_re          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && ctx_ok)
                begin
                    ctx_next  = context_req;
                    base_next = ADDR_W'(32'(cidx_in) * WORDS);
                    unique case (mode)
                        MODE_SEED:
                        begin
                            prev_next   = value;
                            follow_next = FOLLOW_NONE;
                            state_next  = S_SD_W0;
                        end
                        MODE_KEY:
                        begin
                            kb_we = (32'(key_count_reg) < MAX_KEY);
                            if (key_last)
                            begin
                                len_next       = count_inc;
                                key_count_next = '0;
                                prev_next      = KEY_SEED;
                                follow_next    = FOLLOW_KEY;
                                state_next     = S_SD_W0;
                            end
                            else
                            begin
                                key_count_next = count_inc;
                            end
                        end
                        MODE_GEN:
                        begin
                            if (rp_reg[cidx_in] == POS_NEVER)
                            begin
                                prev_next   = DEFAULT_SEED;
                                follow_next = FOLLOW_TWIST;
                                state_next  = S_SD_W0;
                            end
                            else if (rp_reg[cidx_in] == POS_WORDS)
                            begin
                                state_next = S_T_PRE;
                            end
                            else
                            begin
                                state_next = S_G_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SD_W0:
            begin
                sw_we      = 1'b1;
                i_next     = POS_W'(1);
                state_next = S_SD_MUL;
            end

            S_SD_MUL:
            begin
                mult_next  = product;
                state_next = S_SD_WR;
            end

            S_SD_WR:
            begin
                sw_we     = 1'b1;
                sw_waddr  = base_reg + ADDR_W'(i_reg);
                sw_wdata  = mult_reg + WORD_W'(i_reg);
                prev_next = mult_reg + WORD_W'(i_reg);
                if (i_reg == LAST_POS)
                begin
                    rp_we    = 1'b1;
                    rp_wdata = POS_WORDS;
                    unique case (follow_reg)
                        FOLLOW_KEY:
                        begin
                            // The key loop starts at word one; word zero still holds the seed.
                            prev_next  = KEY_SEED;
                            i_next     = POS_W'(1);
                            j_next     = '0;
                            k_next     = '0;
                            phase_next = 1'b0;
                            state_next = S_K_RD;
                        end
                        FOLLOW_TWIST:
                        begin
                            state_next = S_T_PRE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SD_MUL;
                end
            end

            S_K_RD:
            begin
                sw_re      = 1'b1;
                sw_raddr_a = base_reg + ADDR_W'(i_reg);
                kb_re      = 1'b1;
                mult_next  = product;
                state_next = S_K_WR;
            end

            S_K_WR:
            begin
                sw_we     = 1'b1;
                sw_waddr  = base_reg + ADDR_W'(i_reg);
                sw_wdata  = new_word;
                prev_next = new_word;
                j_next    = (j_plus >= len_reg) ? '0 : KIDX'(j_plus);
                k_next    = k_reg + 1'b1;
                if (i_reg == LAST_POS)
                begin
                    i_next     = POS_W'(1);
                    state_next = S_K_W0;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    if ((k_reg + 1'b1) == k_limit)
                    begin
                        k_next     = '0;
                        phase_next = 1'b1;
                        state_next = phase_reg ? S_K_FIN : S_K_RD;
                    end
                    else
                    begin
                        state_next = S_K_RD;
                    end
                end
            end

            S_K_W0:
            begin
                // Word zero takes a copy of the last word after each wrap.
                sw_we = 1'b1;
                if (k_reg == k_limit)
                begin
                    k_next     = '0;
                    phase_next = 1'b1;
                    state_next = phase_reg ? S_K_FIN : S_K_RD;
                end
                else
                begin
                    state_next = S_K_RD;
                end
            end

            S_K_FIN:
            begin
                sw_we      = 1'b1;
                sw_wdata   = HIGH_BIT;
                state_next = S_IDLE;
            end

            S_T_PRE:
            begin
                sw_re      = 1'b1;
                k_next     = '0;
                far_next   = POS_FAR0;
                state_next = S_T_LD;
            end

            S_T_LD:
            begin
                cur_next   = sw_rdata_b;
                state_next = S_T_RD;
            end

            S_T_RD:
            begin
                sw_re      = 1'b1;
                sw_raddr_a = base_reg + ADDR_W'(far_reg);
                sw_raddr_b = base_reg + ((k_reg == LAST_POS) ? '0 : ADDR_W'(k_reg + 1'b1));
                state_next = S_T_WR;
            end

            S_T_WR:
            begin
                sw_we    = 1'b1;
                sw_waddr = base_reg + ADDR_W'(k_reg);
                sw_wdata = sw_rdata_a ^ (twist_v >> 1) ^ (twist_v[0] ? TWIST_XOR : '0);
                cur_next = sw_rdata_b;
                far_next = (far_reg == LAST_POS) ? '0 : far_reg + 1'b1;
                if (k_reg == LAST_POS)
                begin
                    rp_we      = 1'b1;
                    rp_wdata   = '0;
                    state_next = S_G_RD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_T_RD;
                end
            end

            S_G_RD:
            begin
                sw_re      = 1'b1;
                sw_raddr_a = base_reg + ADDR_W'(rp_cur);
                state_next = S_G_OUT;
            end

            S_G_OUT:
            begin
                // Waits here while an earlier word is still held on the output.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = temper(sw_rdata_a);
                    out_ctx_next   = ctx_reg;
                    rp_we          = 1'b1;
                    rp_wdata       = rp_cur + 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            follow_reg    <= FOLLOW_NONE;
            phase_reg     <= 1'b0;
            key_count_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CONTEXTS; c++)
            begin
                rp_reg[c] <= POS_NEVER;
            end
        end
        else
        begin
            state_reg     <= state_next;
            follow_reg    <= follow_next;
            phase_reg     <= phase_next;
            key_count_reg <= key_count_next;
            out_valid_reg <= out_valid_next;
            if (rp_we)
            begin
                rp_reg[rp_idx] <= rp_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg      <= ctx_next;
        base_reg     <= base_next;
        i_reg        <= i_next;
        k_reg        <= k_next;
        far_reg      <= far_next;
        j_reg        <= j_next;
        len_reg      <= len_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        mult_reg     <= mult_next;
        out_word_reg <= out_word_next;
        out_ctx_reg  <= out_ctx_next;
    end

    // Two mirrored copies of the state words give two read ports.
    mtg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CONTEXTS * WORDS)
    ) u_state_a (
        .clk   (clk),
        .we    (sw_we),
        .waddr (sw_waddr),
        .wdata (sw_wdata),
        .re    (sw_re),
        .raddr (sw_raddr_a),
        .rdata (sw_rdata_a)
    );

    mtg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CONTEXTS * WORDS)
    ) u_state_b (
        .clk   (clk),
        .we    (sw_we),
        .waddr (sw_waddr),
        .wdata (sw_wdata),
        .re    (sw_re),
        .raddr (sw_raddr_b),
        .rdata (sw_rdata_b)
    );

    mtg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_KEY)
    ) u_key_buf (
        .clk   (clk),
        .we    (kb_we),
        .waddr (kb_waddr),
        .wdata (value),
        .re    (kb_re),
        .raddr (j_reg),
        .rdata (kb_rdata)
    );

endmodule

>>> hw/rtl/mtg_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Used for the context state words and the key buffer; no package needed.
module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read enable.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
